// ----- design/epaf_pkg.sv -----
// Package for the edge pair angle factor block.
// Field widths, table row layout, sequencer states and fixed-point constants.
// No dependencies.
package epaf_pkg;

    localparam int CORNER_W         = 20;
    localparam int EDGE_W           = 14;
    localparam int NORMAL_W         = 24;
    localparam int CODE_W           = 8;
    localparam int CNT_W            = 3;
    localparam int EDGE_COUNT       = 16384;
    localparam int NORMAL_FRAC_BITS = 22;

    localparam int EDGE_AW = (EDGE_COUNT > 1) ? $clog2(EDGE_COUNT) : 1;
    localparam int PROD_W  = 2 * NORMAL_W;
    localparam int DOT_W   = PROD_W + 2;
    localparam int F2      = 2 * NORMAL_FRAC_BITS;
    localparam int NUM_W   = F2 + 1;
    localparam int RND_W   = NUM_W + CODE_W;

    localparam longint unsigned ONE_VAL = 64'd1 << F2;
    localparam longint unsigned LIM_VAL = (ONE_VAL + 64'd199) / 64'd200;

    localparam logic signed [DOT_W:0] ONE_EXT = (DOT_W+1)'(ONE_VAL);
    localparam logic signed [DOT_W:0] LIM_EXT = (DOT_W+1)'(LIM_VAL);
    localparam logic [NUM_W-1:0]      ONE_NUM = NUM_W'(ONE_VAL);
    localparam logic [NUM_W-1:0]      ANGLE_GAIN = NUM_W'(200);
    localparam logic [RND_W-1:0]      CODE_SCALE = RND_W'(254);
    localparam logic [RND_W-1:0]      HALF_RND = RND_W'(ONE_VAL >> 1);

    localparam logic [CNT_W-1:0]  CNT_SAT      = CNT_W'(4);
    localparam logic [CODE_W-1:0] CODE_VISIBLE = 8'd0;
    localparam logic [CODE_W-1:0] CODE_FLAT    = 8'd254;
    localparam logic [CODE_W-1:0] CODE_HIDDEN  = 8'd255;

    localparam logic REG_FILTER = 1'b0;

    typedef struct packed {
        logic [CNT_W-1:0]           cnt;
        logic [CORNER_W-1:0]        first;
        logic [CORNER_W-1:0]        second;
        logic signed [NORMAL_W-1:0] nx;
        logic signed [NORMAL_W-1:0] ny;
        logic signed [NORMAL_W-1:0] nz;
    } t_row;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_LOOK,
        S_MUL,
        S_ACC,
        S_CMP,
        S_NUM,
        S_CODE,
        S_OUT
    } t_state;

endpackage

// ----- design/edge_pair_angle_factor.sv -----
// Edge pair angle factor: per-edge face table and angle code sequencer.
// Depends on epaf_pkg.
//
//  channel | handshake            | payload
//  in      | i_valid / o_stall    | corner_index, edge_index, edge_shown, normal_x/y/z
//  out     | o_valid / i_stall    | write_corner, factor_code, last_write
//  config  | psel/penable/pready  | display_filter_enable at word 0
//
// Reset starts a clearing pass over all EDGE_COUNT (16384) table entries,
// with o_stall high throughout.
// An item passes S_READ and S_LOOK, then S_OUT sends its results; a second face
// first runs the shared multiplier (three products) in S_MUL, S_ACC and S_CMP,
// then rounds in S_NUM and S_CODE, skipped when the code clamps to 0 or 254.
// The table port serves one read and at most one write per item; results
// drain through one output register that holds while i_stall is high.
module edge_pair_angle_factor
    import epaf_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [CORNER_W-1:0]        i_corner_index,
    input  logic [EDGE_W-1:0]          i_edge_index,
    input  logic                       i_edge_shown,
    input  logic signed [NORMAL_W-1:0] i_normal_x,
    input  logic signed [NORMAL_W-1:0] i_normal_y,
    input  logic signed [NORMAL_W-1:0] i_normal_z,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [CORNER_W-1:0]        o_write_corner,
    output logic [CODE_W-1:0]          o_factor_code,
    output logic                       o_last_write,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    t_row mem [EDGE_COUNT];

    t_state r_state, n_state;
    logic [EDGE_AW-1:0] r_clr;
    logic r_filter;

    logic [CORNER_W-1:0]        r_corner;
    logic [EDGE_W-1:0]          r_edge;
    logic                       r_shown;
    logic signed [NORMAL_W-1:0] r_nx, r_ny, r_nz;

    t_row r_rd;
    logic [1:0] r_step;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [DOT_W-1:0]  r_acc;
    logic [NUM_W-1:0] r_d;
    logic [NUM_W-1:0] r_num;
    logic [CODE_W-1:0] r_code;
    logic [CORNER_W-1:0] r_res [3];
    logic [1:0] r_nres;
    logic [1:0] r_k;

    logic r_o_valid;
    logic [CORNER_W-1:0] r_o_corner;
    logic [CODE_W-1:0] r_o_code;
    logic r_o_last;

    logic in_acc;
    logic hidden, out_range, saturated, do_write;
    logic mem_we;
    logic [EDGE_AW-1:0] mem_addr;
    t_row mem_wdata;
    t_row upd_row;
    logic signed [NORMAL_W-1:0] mul_a, mul_b;
    logic signed [DOT_W:0] d_full;
    logic [NUM_W-1:0] scaled;
    logic [RND_W-1:0] rnd;
    logic out_load, out_is_last;
    logic cfg_wr;

    assign in_acc    = i_valid && (r_state == S_IDLE);
    assign o_stall   = (r_state != S_IDLE);
    assign hidden    = r_filter && !r_shown;
    assign out_range = ({1'b0, r_edge} >= (EDGE_W+1)'(EDGE_COUNT));
    assign saturated = (r_rd.cnt >= CNT_SAT);
    assign do_write  = !hidden && !out_range && !saturated;

    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FILTER) ? {31'd0, r_filter} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter <= 1'b0;
        end else if (cfg_wr && (paddr[2] == REG_FILTER)) begin
            r_filter <= pwdata[0];
        end
    end

    always_comb begin
        upd_row     = r_rd;
        upd_row.cnt = r_rd.cnt + CNT_W'(1);
        if (r_rd.cnt == CNT_W'(0)) begin
            upd_row.first = r_corner;
            upd_row.nx    = r_nx;
            upd_row.ny    = r_ny;
            upd_row.nz    = r_nz;
        end else if (r_rd.cnt == CNT_W'(1)) begin
            upd_row.second = r_corner;
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_addr  = r_edge[EDGE_AW-1:0];
        mem_wdata = upd_row;
        if (r_state == S_CLEAR) begin
            mem_we    = 1'b1;
            mem_addr  = r_clr;
            mem_wdata = '0;
        end else if (r_state == S_LOOK) begin
            mem_we = do_write;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end
        if (r_state == S_READ) begin
            r_rd <= mem[mem_addr];
        end
    end

    always_comb begin
        case (r_step)
            2'd0: begin
                mul_a = r_rd.nx;
                mul_b = r_nx;
            end
            2'd1: begin
                mul_a = r_rd.ny;
                mul_b = r_ny;
            end
            default: begin
                mul_a = r_rd.nz;
                mul_b = r_nz;
            end
        endcase
    end

    assign d_full = ONE_EXT - {r_acc[DOT_W-1], r_acc};
    assign scaled = r_d * ANGLE_GAIN;
    assign rnd    = {{CODE_W{1'b0}}, r_num} * CODE_SCALE + HALF_RND;

    assign out_load    = !r_o_valid || !i_stall;
    assign out_is_last = (r_k == (r_nres - 2'd1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr == EDGE_AW'(EDGE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_READ;
                end
            end
            S_READ: n_state = S_LOOK;
            S_LOOK: begin
                if (do_write && (r_rd.cnt == CNT_W'(1))) begin
                    n_state = S_MUL;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_MUL: begin
                if (r_step == 2'd2) begin
                    n_state = S_ACC;
                end
            end
            S_ACC: n_state = S_CMP;
            S_CMP: begin
                if (!(r_acc >= $signed(ONE_EXT[DOT_W-1:0])) && !(d_full >= LIM_EXT)) begin
                    n_state = S_NUM;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_NUM:  n_state = S_CODE;
            S_CODE: n_state = S_OUT;
            S_OUT: begin
                if (out_load && out_is_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + EDGE_AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_corner <= i_corner_index;
            r_edge   <= i_edge_index;
            r_shown  <= i_edge_shown;
            r_nx     <= i_normal_x;
            r_ny     <= i_normal_y;
            r_nz     <= i_normal_z;
        end
        case (r_state)
            S_LOOK: begin
                r_k    <= 2'd0;
                r_step <= 2'd0;
                if (hidden) begin
                    r_code   <= CODE_HIDDEN;
                    r_res[0] <= r_corner;
                    r_nres   <= 2'd1;
                end else if (do_write && (r_rd.cnt == CNT_W'(1))) begin
                    r_code   <= CODE_VISIBLE;
                    r_res[0] <= r_rd.first;
                    r_res[1] <= r_corner;
                    r_nres   <= 2'd2;
                end else if (do_write && (r_rd.cnt != CNT_W'(0))) begin
                    r_code   <= CODE_VISIBLE;
                    r_res[0] <= r_rd.first;
                    r_res[1] <= r_rd.second;
                    r_res[2] <= r_corner;
                    r_nres   <= 2'd3;
                end else begin
                    r_code   <= CODE_VISIBLE;
                    r_res[0] <= r_corner;
                    r_nres   <= 2'd1;
                end
            end
            S_MUL: begin
                r_prod <= mul_a * mul_b;
                r_step <= r_step + 2'd1;
                if (r_step == 2'd0) begin
                    r_acc <= '0;
                end else begin
                    r_acc <= r_acc + DOT_W'(r_prod);
                end
            end
            S_ACC: r_acc <= r_acc + DOT_W'(r_prod);
            S_CMP: begin
                if (r_acc >= $signed(ONE_EXT[DOT_W-1:0])) begin
                    r_code <= CODE_FLAT;
                end else if (d_full >= LIM_EXT) begin
                    r_code <= CODE_VISIBLE;
                end else begin
                    r_d <= d_full[NUM_W-1:0];
                end
            end
            S_NUM:  r_num  <= ONE_NUM - scaled;
            S_CODE: r_code <= rnd[F2+CODE_W-1:F2];
            S_OUT: begin
                if (out_load) begin
                    r_k <= r_k + 2'd1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= (r_state == S_OUT);
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load && (r_state == S_OUT)) begin
            r_o_corner <= r_res[r_k];
            r_o_code   <= r_code;
            r_o_last   <= out_is_last;
        end
    end

    assign o_valid        = r_o_valid;
    assign o_write_corner = r_o_corner;
    assign o_factor_code  = r_o_code;
    assign o_last_write   = r_o_last;

endmodule

// ----- design/epaf_checker.sv -----
// Port-level checker for edge_pair_angle_factor, bound to the top level.
// Depends on epaf_pkg.
module epaf_checker
    import epaf_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [CORNER_W-1:0] o_write_corner,
    input logic [CODE_W-1:0]   o_factor_code,
    input logic                o_last_write
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_write_corner)
            && $stable(o_factor_code) && $stable(o_last_write))
        else $error("stalled result changed");

    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> o_stall)
        else $error("item taken during table clear");

    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall ##1 o_stall)
        else $error("item taken before table update");

    a_busy_mid_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_write |-> o_stall)
        else $error("item taken while results pending");

    a_hidden_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_factor_code == CODE_HIDDEN) |-> o_last_write)
        else $error("hidden edge gave more than one result");

endmodule

bind edge_pair_angle_factor epaf_checker u_epaf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_write_corner (o_write_corner),
    .o_factor_code  (o_factor_code),
    .o_last_write   (o_last_write)
);
